// ----- hw/rtl/lapic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapic_pkg
// Types and constants shared by the local interrupt controller timer block
// and its channel interfaces.
// ----------------------------------------------------------------------------
package lapic_pkg;

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    localparam logic [5:0] REG_ID    = 6'h02;
    localparam logic [5:0] REG_EOI   = 6'h0b;
    localparam logic [5:0] REG_SPUR  = 6'h0f;
    localparam logic [2:0] REG_ISR_HI = 3'b010;
    localparam logic [5:0] REG_ICRLO = 6'h30;
    localparam logic [5:0] REG_ICRHI = 6'h31;
    localparam logic [5:0] REG_LVT   = 6'h32;
    localparam logic [5:0] REG_INIT  = 6'h38;
    localparam logic [5:0] REG_CUR   = 6'h39;
    localparam logic [5:0] REG_DIV   = 6'h3e;

    localparam logic [0:0] CFG_APIC_ID   = 1'b0;
    localparam logic [0:0] CFG_GLOBAL_EN = 1'b1;

    localparam int         LVT_MASK_BIT     = 16;
    localparam int         LVT_PERIODIC_BIT = 17;
    localparam int         DLV_STATUS_BIT   = 12;
    localparam int         SW_ENABLE_BIT    = 8;
    localparam logic [3:0] DIV_KEEP         = 4'hb;
    localparam logic [31:0] SPUR_RESET      = 32'h0000_00ff;

    typedef struct packed {
        logic [1:0]  func;
        logic [5:0]  reg_index;
        logic [31:0] write_data;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic        timer_fired;
        logic [7:0]  fired_vector;
        logic        ipi_valid;
        logic [7:0]  ipi_dest;
        logic [7:0]  ipi_type;
        logic [7:0]  ipi_vector;
    } t_rsp;

endpackage

// ----- hw/rtl/lapic_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapic_req_if
// Valid/ready channel that carries one request: a read, a write or a tick.
// ----------------------------------------------------------------------------
interface lapic_req_if import lapic_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/lapic_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lapic_rsp_if
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
interface lapic_rsp_if import lapic_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/local_apic_timer_and_ipi_block_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_apic_timer_and_ipi_block_core
// Register file subset of a local interrupt controller with an interval
// timer, in-service tracking and an inter-processor interrupt sender.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake      Payload
//   i_req     in    valid/ready    func, reg_index, write_data
//   o_rsp     out   valid/ready    read_data, timer, IPI fields
//   i_cfg_*   in    write enable   apic_id, global_enable
//
// Each request is handled in the cycle it is accepted and its result is held
// in one output register, so one request per cycle is sustained while the receiver keeps taking results.
// A request is accepted whenever the output register is empty or is being
// drained in the same cycle; a stalled result blocks only further requests.
// Reset is synchronous and active low and restores every state register and
// clears the result valid flag; the result payload itself is not reset.
// No clearing pass is needed.
// ----------------------------------------------------------------------------
module local_apic_timer_and_ipi_block_core
    import lapic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_wr_data,
    lapic_req_if.sink   i_req,
    lapic_rsp_if.source o_rsp
);

    logic [7:0]  r_apic_id;
    logic        r_global_en;
    logic [31:0] r_spur, n_spur;
    logic [31:0] r_isr [8];
    logic [31:0] n_isr [8];
    logic [31:0] r_icr_hi, n_icr_hi;
    logic [31:0] r_icr_lo, n_icr_lo;
    logic [7:0]  r_lvt_vector, n_lvt_vector;
    logic        r_lvt_mask, n_lvt_mask;
    logic        r_lvt_periodic, n_lvt_periodic;
    logic [31:0] r_init_count, n_init_count;
    logic [31:0] r_cur_count, n_cur_count;
    logic [3:0]  r_div_code, n_div_code;
    logic [6:0]  r_prescale, n_prescale;
    logic        r_out_valid;
    t_rsp        r_out, n_out;

    logic        accept;
    t_req        req;
    logic [2:0]  div_sel;
    logic [7:0]  div_val;
    logic [6:0]  div_m1;
    logic        pre_wrap;
    logic [31:0] cnt_dec;
    logic [7:0]  word_any;
    logic [2:0]  top_word;
    logic [31:0] top_bits;
    logic [31:0] top_onehot;

    assign req         = i_req.payload;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_out;

    assign div_sel  = {r_div_code[3], r_div_code[1:0]};
    assign div_val  = 8'd1 << ({1'b0, div_sel} + 4'd1);
    assign div_m1   = div_val[6:0] - 7'd1;
    assign pre_wrap = (div_sel == 3'd7) || (r_prescale >= div_m1);
    assign cnt_dec  = r_cur_count - 32'd1;

    always_comb begin
        top_word = 3'd0;
        for (int w = 0; w < 8; w++) begin
            word_any[w] = |r_isr[w];
            if (word_any[w]) begin
                top_word = 3'(w);
            end
        end
        top_bits = r_isr[top_word];
        for (int b = 0; b < 32; b++) begin
            top_onehot[b] = top_bits[b] && ((top_bits >> (b + 1)) == 32'd0);
        end
    end

    always_comb begin
        n_spur         = r_spur;
        n_isr          = r_isr;
        n_icr_hi       = r_icr_hi;
        n_icr_lo       = r_icr_lo;
        n_lvt_vector   = r_lvt_vector;
        n_lvt_mask     = r_lvt_mask;
        n_lvt_periodic = r_lvt_periodic;
        n_init_count   = r_init_count;
        n_cur_count    = r_cur_count;
        n_div_code     = r_div_code;
        n_prescale     = r_prescale;
        n_out          = '0;

        unique case (req.func)
            FUNC_READ: begin
                if (req.reg_index[5:3] == REG_ISR_HI) begin
                    n_out.read_data = r_isr[req.reg_index[2:0]];
                end else begin
                    case (req.reg_index)
                        REG_ID:    n_out.read_data = {r_apic_id, 24'd0};
                        REG_SPUR:  n_out.read_data = r_spur;
                        REG_ICRLO: n_out.read_data = r_icr_lo;
                        REG_ICRHI: n_out.read_data = r_icr_hi;
                        REG_LVT:   n_out.read_data = {14'd0, r_lvt_periodic, r_lvt_mask,
                                                      8'd0, r_lvt_vector};
                        REG_INIT:  n_out.read_data = r_init_count;
                        REG_CUR:   n_out.read_data = r_cur_count;
                        REG_DIV:   n_out.read_data = {28'd0, r_div_code};
                        default:   n_out.read_data = 32'd0;
                    endcase
                end
            end
            FUNC_WRITE: begin
                case (req.reg_index)
                    REG_EOI: begin
                        if (|word_any) begin
                            n_isr[top_word] = top_bits & ~top_onehot;
                        end
                    end
                    REG_SPUR:  n_spur = req.write_data;
                    REG_ICRHI: n_icr_hi = req.write_data;
                    REG_ICRLO: begin
                        n_icr_lo = req.write_data;
                        n_icr_lo[DLV_STATUS_BIT] = 1'b0;
                        if (r_global_en) begin
                            n_out.ipi_valid  = 1'b1;
                            n_out.ipi_dest   = r_icr_hi[31:24];
                            n_out.ipi_type   = req.write_data[15:8];
                            n_out.ipi_vector = req.write_data[7:0];
                        end
                    end
                    REG_LVT: begin
                        n_lvt_vector   = req.write_data[7:0];
                        n_lvt_mask     = req.write_data[LVT_MASK_BIT];
                        n_lvt_periodic = req.write_data[LVT_PERIODIC_BIT];
                    end
                    REG_INIT: begin
                        n_init_count = req.write_data;
                        n_cur_count  = req.write_data;
                        n_prescale   = 7'd0;
                    end
                    REG_DIV: n_div_code = req.write_data[3:0] & DIV_KEEP;
                    default: ;
                endcase
            end
            FUNC_TICK: begin
                if (r_global_en && (r_cur_count != 32'd0)) begin
                    if (pre_wrap) begin
                        n_prescale  = 7'd0;
                        n_cur_count = cnt_dec;
                        if (cnt_dec == 32'd0) begin
                            if (r_lvt_periodic) begin
                                n_cur_count = r_init_count;
                            end
                            if (!r_lvt_mask && r_spur[SW_ENABLE_BIT]) begin
                                n_isr[r_lvt_vector[7:5]][r_lvt_vector[4:0]] = 1'b1;
                                n_out.timer_fired  = 1'b1;
                                n_out.fired_vector = r_lvt_vector;
                            end
                        end
                    end else begin
                        n_prescale = r_prescale + 7'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apic_id      <= 8'd0;
            r_global_en    <= 1'b0;
            r_spur         <= SPUR_RESET;
            r_isr          <= '{default: 32'd0};
            r_icr_hi       <= 32'd0;
            r_icr_lo       <= 32'd0;
            r_lvt_vector   <= 8'd0;
            r_lvt_mask     <= 1'b1;
            r_lvt_periodic <= 1'b0;
            r_init_count   <= 32'd0;
            r_cur_count    <= 32'd0;
            r_div_code     <= 4'd0;
            r_prescale     <= 7'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_APIC_ID:   r_apic_id <= i_cfg_wr_data;
                    CFG_GLOBAL_EN: r_global_en <= i_cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_spur         <= n_spur;
                r_isr          <= n_isr;
                r_icr_hi       <= n_icr_hi;
                r_icr_lo       <= n_icr_lo;
                r_lvt_vector   <= n_lvt_vector;
                r_lvt_mask     <= n_lvt_mask;
                r_lvt_periodic <= n_lvt_periodic;
                r_init_count   <= n_init_count;
                r_cur_count    <= n_cur_count;
                r_div_code     <= n_div_code;
                r_prescale     <= n_prescale;
                r_out_valid    <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_id_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (req.func == FUNC_READ) && (req.reg_index == REG_ID) && !i_cfg_wr_en
        |=> (r_out.read_data == {$past(r_apic_id), 24'd0}))
        else $error("ID read does not return the identifier");

    a_tick_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (req.func == FUNC_TICK) && !r_global_en
        |=> $stable(r_cur_count) && $stable(r_prescale))
        else $error("Timer moved while globally disabled");

    a_fire_sets_isr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.timer_fired
        |-> r_isr[r_out.fired_vector[7:5]][r_out.fired_vector[4:0]])
        else $error("Fired vector is not marked in service");

    a_ipi_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.ipi_valid
        |-> !r_out.timer_fired && (r_out.read_data == 32'd0))
        else $error("IPI result carries timer or read data");
`endif

endmodule

// ----- verif/local_apic_timer_and_ipi_block_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_apic_timer_and_ipi_block_core_test
// Self-checking testbench for the local interrupt controller timer and IPI
// block. A directed opening covers reset values, timer expiry, EOI, IPI
// sending and ignored accesses. Phases of randomized timer programs, IPI
// sequences and noise requests follow under changing configuration, sender
// gaps and receiver stalls. A state mirror predicts every response, and
// responses are compared with the predictions in order.
// ----------------------------------------------------------------------------
import lapic_pkg::*;

class apic_state_mirror;
    logic [7:0]  apic_id;
    logic        global_en;
    logic [31:0] spur;
    logic [31:0] isr [8];
    logic [31:0] icr_hi;
    logic [31:0] icr_lo;
    logic [31:0] lvt;
    logic [31:0] init_cnt;
    logic [31:0] cur_cnt;
    logic [3:0]  div_code;
    int unsigned prescale;
    t_rsp        owed_responses [$];
    int          error_count;

    function new();
        apic_id   = '0;
        global_en = 1'b0;
        spur      = SPUR_RESET;
        foreach (isr[w]) isr[w] = '0;
        icr_hi    = '0;
        icr_lo    = '0;
        lvt       = '0;
        lvt[LVT_MASK_BIT] = 1'b1;
        init_cnt  = '0;
        cur_cnt   = '0;
        div_code  = '0;
        prescale  = 0;
        error_count = 0;
    endfunction

    function int pending();
        return owed_responses.size();
    endfunction

    function void set_config(logic [0:0] idx, logic [7:0] data);
        if (idx == CFG_APIC_ID) begin
            apic_id = data;
        end else begin
            global_en = data[0];
        end
    endfunction

    function int unsigned tick_divisor();
        logic [2:0] d;
        d = {div_code[3], div_code[1:0]};
        return (d == 3'd7) ? 1 : (1 << (d + 1));
    endfunction

    function void retire_highest();
        for (int w = 7; w >= 0; w--) begin
            if (isr[w] != '0) begin
                for (int b = 31; b >= 0; b--) begin
                    if (isr[w][b]) begin
                        isr[w][b] = 1'b0;
                        return;
                    end
                end
            end
        end
    endfunction

    function logic [31:0] reg_value(logic [5:0] idx);
        if (idx[5:3] == REG_ISR_HI) return isr[idx[2:0]];
        case (idx)
            REG_ID:    return {apic_id, 24'h0};
            REG_SPUR:  return spur;
            REG_ICRLO: return icr_lo;
            REG_ICRHI: return icr_hi;
            REG_LVT:   return lvt;
            REG_INIT:  return init_cnt;
            REG_CUR:   return cur_cnt;
            REG_DIV:   return {28'h0, div_code};
            default:   return '0;
        endcase
    endfunction

    function void note_request(t_req r);
        t_rsp        e;
        logic [7:0]  vec;
        e = '0;
        case (r.func)
            FUNC_READ: begin
                e.read_data = reg_value(r.reg_index);
            end
            FUNC_WRITE: begin
                case (r.reg_index)
                    REG_EOI:   retire_highest();
                    REG_SPUR:  spur = r.write_data;
                    REG_ICRHI: icr_hi = r.write_data;
                    REG_ICRLO: begin
                        icr_lo = r.write_data;
                        icr_lo[DLV_STATUS_BIT] = 1'b0;
                        if (global_en) begin
                            e.ipi_valid  = 1'b1;
                            e.ipi_dest   = icr_hi[31:24];
                            e.ipi_type   = r.write_data[15:8];
                            e.ipi_vector = r.write_data[7:0];
                        end
                    end
                    REG_LVT: begin
                        lvt = '0;
                        lvt[7:0] = r.write_data[7:0];
                        lvt[LVT_MASK_BIT] = r.write_data[LVT_MASK_BIT];
                        lvt[LVT_PERIODIC_BIT] = r.write_data[LVT_PERIODIC_BIT];
                    end
                    REG_INIT: begin
                        init_cnt = r.write_data;
                        cur_cnt  = r.write_data;
                        prescale = 0;
                    end
                    REG_DIV: div_code = r.write_data[3:0] & DIV_KEEP;
                    default: ;
                endcase
            end
            FUNC_TICK: begin
                if (global_en && cur_cnt != '0) begin
                    if (prescale + 1 >= tick_divisor()) begin
                        prescale = 0;
                        cur_cnt = cur_cnt - 32'd1;
                        if (cur_cnt == '0) begin
                            if (lvt[LVT_PERIODIC_BIT]) cur_cnt = init_cnt;
                            if (!lvt[LVT_MASK_BIT] && spur[SW_ENABLE_BIT]) begin
                                vec = lvt[7:0];
                                isr[vec[7:5]][vec[4:0]] = 1'b1;
                                e.timer_fired  = 1'b1;
                                e.fired_vector = vec;
                            end
                        end
                    end else begin
                        prescale = prescale + 1;
                    end
                end
            end
            default: ;
        endcase
        owed_responses.push_back(e);
    endfunction

    task report_mismatch(string msg);
        error_count++;
        if (error_count <= 40) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task check_result(t_rsp got);
        t_rsp want;
        if (owed_responses.size() == 0) begin
            report_mismatch("response with no request outstanding");
            return;
        end
        want = owed_responses.pop_front();
        compare_field("read_data", got.read_data, want.read_data);
        compare_field("timer_fired", 32'(got.timer_fired), 32'(want.timer_fired));
        compare_field("fired_vector", 32'(got.fired_vector), 32'(want.fired_vector));
        compare_field("ipi_valid", 32'(got.ipi_valid), 32'(want.ipi_valid));
        compare_field("ipi_dest", 32'(got.ipi_dest), 32'(want.ipi_dest));
        compare_field("ipi_type", 32'(got.ipi_type), 32'(want.ipi_type));
        compare_field("ipi_vector", 32'(got.ipi_vector), 32'(want.ipi_vector));
    endtask
endclass

module local_apic_timer_and_ipi_block_core_test;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          LONG_HOLD    = 160;
    localparam int          RANDOM_ITEMS = 1700;
    localparam int          PHASES       = 8;
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
    localparam logic [5:0]  REG_UNMAPPED_LO = 6'h00;
    localparam logic [5:0]  REG_UNMAPPED_HI = 6'h3f;
    localparam logic [5:0]  REG_ISR_BASE    = {REG_ISR_HI, 3'b000};

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_COIN} rx_mode_e;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [0:0]  i_cfg_index;
    logic [7:0]  i_cfg_wr_data;

    lapic_req_if req_if ();
    lapic_rsp_if rsp_if ();

    local_apic_timer_and_ipi_block_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    apic_state_mirror mirror;
    rx_mode_e         stall_mode;
    int unsigned      holds_requested;
    bit               gaps_on;
    int unsigned      burst_left;
    int unsigned      items_sent;
    int unsigned      cycle_count;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            mirror.check_result(rsp_if.payload);
        end
    end

    initial begin
        int unsigned hold_left;
        int unsigned holds_served;
        int unsigned pattern_pos;
        hold_left    = 0;
        holds_served = 0;
        pattern_pos  = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            pattern_pos++;
            if (holds_served != holds_requested) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    RX_ALWAYS:  rsp_if.ready <= 1'b1;
                    RX_RANDOM:  rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_PATTERN: rsp_if.ready <= ((pattern_pos % 5) < 3);
                    default:    rsp_if.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    function automatic t_req req_of(logic [1:0] f, logic [5:0] idx, logic [31:0] d);
        t_req r;
        r.func       = f;
        r.reg_index  = idx;
        r.write_data = d;
        return r;
    endfunction

    function automatic logic [5:0] pick_index();
        case ($urandom_range(0, 11))
            0:       return REG_ID;
            1:       return REG_EOI;
            2:       return REG_SPUR;
            3:       return REG_ICRLO;
            4:       return REG_ICRHI;
            5:       return REG_LVT;
            6:       return REG_INIT;
            7, 8:    return REG_CUR;
            9:       return REG_DIV;
            10:      return {REG_ISR_HI, 3'($urandom)};
            default: return 6'($urandom);
        endcase
    endfunction

    task automatic send_item(t_req r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if (gaps_on) begin
                gap = $urandom_range(0, 6);
                repeat (gap) begin
                    @(negedge i_clk);
                    req_if.valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        mirror.note_request(r);
        items_sent++;
    endtask

    task automatic rd(logic [5:0] idx);
        send_item(req_of(FUNC_READ, idx, $urandom));
    endtask

    task automatic wr(logic [5:0] idx, logic [31:0] d);
        send_item(req_of(FUNC_WRITE, idx, d));
    endtask

    task automatic tick();
        send_item(req_of(FUNC_TICK, 6'($urandom), $urandom));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (mirror.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic configure(logic [7:0] id, logic en);
        logic [7:0] en_data;
        en_data = {7'($urandom), en};
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= CFG_APIC_ID;
        i_cfg_wr_data <= id;
        @(negedge i_clk);
        i_cfg_index   <= CFG_GLOBAL_EN;
        i_cfg_wr_data <= en_data;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        mirror.set_config(CFG_APIC_ID, id);
        mirror.set_config(CFG_GLOBAL_EN, en_data);
    endtask

    task automatic ipi_sequence();
        wr(REG_ICRHI, $urandom);
        wr(REG_ICRLO, $urandom);
        if ($urandom_range(0, 1) != 0) rd(REG_ICRLO);
        if ($urandom_range(0, 3) == 0) rd(REG_ICRHI);
    endtask

    task automatic noise_item();
        send_item(req_of(2'($urandom), 6'($urandom), $urandom));
    endtask

    task automatic timer_program();
        logic [31:0] d;
        logic [31:0] cnt;
        int unsigned span;
        int unsigned roll;
        d = $urandom;
        d[SW_ENABLE_BIT] = ($urandom_range(0, 6) != 0);
        wr(REG_SPUR, d);
        d = $urandom;
        d[LVT_MASK_BIT] = ($urandom_range(0, 4) == 0);
        wr(REG_LVT, d);
        d = $urandom;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            d[3:0] = 4'hb;
        end else if (roll < 9) begin
            d[3:0] = {2'b00, 2'($urandom)};
        end
        wr(REG_DIV, d);
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
            cnt = $urandom_range(0, 4);
        end else if (roll < 97) begin
            cnt = $urandom_range(5, 32);
        end else begin
            cnt = $urandom;
        end
        wr(REG_INIT, cnt);
        if (cnt <= 32) begin
            span = cnt * mirror.tick_divisor() + $urandom_range(0, 3);
        end else begin
            span = $urandom_range(8, 40);
        end
        if (span > 160) span = 160;
        for (int unsigned n = 0; n < span; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                tick();
            end else if (roll < 80) begin
                rd(pick_index());
            end else if (roll < 86) begin
                wr(REG_EOI, $urandom);
            end else if (roll < 90) begin
                ipi_sequence();
            end else begin
                noise_item();
            end
        end
        if ($urandom_range(0, 2) == 0) rd({REG_ISR_HI, 3'($urandom)});
        if ($urandom_range(0, 2) == 0) wr(REG_EOI, $urandom);
    endtask

    task automatic directed_checks();
        rd(REG_ID);
        rd(REG_SPUR);
        rd(REG_LVT);
        wr(REG_SPUR, 32'h0000_01ff);
        wr(REG_DIV, 32'hffff_fffb);
        rd(REG_DIV);
        // Periodic, unmasked, low vector, divide by one.
        wr(REG_LVT, 32'hfffe_ff05);
        wr(REG_INIT, 32'd2);
        tick();
        tick();
        rd(REG_CUR);
        rd(REG_ISR_BASE);
        // A stopped timer ignores ticks.
        wr(REG_INIT, 32'd0);
        tick();
        wr(REG_EOI, $urandom);
        wr(REG_EOI, 32'h0);
        wr(REG_ICRHI, 32'hffff_ffff);
        wr(REG_ICRLO, 32'hffff_ffff);
        rd(REG_ICRLO);
        // Writes to read-only and unmapped registers are dropped.
        wr(REG_ID, 32'hffff_ffff);
        wr(REG_CUR, 32'hffff_ffff);
        wr(REG_UNMAPPED_LO, 32'hffff_ffff);
        rd(REG_UNMAPPED_HI);
        send_item(req_of(FUNC_UNUSED, REG_INIT, 32'hffff_ffff));
        // With software enable off an expiry raises nothing.
        wr(REG_SPUR, 32'h0);
        wr(REG_LVT, 32'h0000_00ff);
        wr(REG_INIT, 32'd1);
        tick();
        wr(REG_INIT, 32'hffff_ffff);
        rd(REG_CUR);
    endtask

    initial begin
        int unsigned target;
        int unsigned roll;
        bit          paused;
        mirror          = new();
        stall_mode      = RX_ALWAYS;
        holds_requested = 0;
        gaps_on         = 1'b0;
        burst_left      = 0;
        items_sent      = 0;
        cycle_count     = 0;
        paused          = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_wr_data   = '0;
        req_if.valid    = 1'b0;
        req_if.payload  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        configure(8'hff, 1'b1);
        directed_checks();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       configure(8'h00, 1'b1);
                1:       configure(8'hff, 1'b1);
                3, 6:    configure(8'($urandom), 1'b0);
                5:       configure(8'hff, 1'b1);
                default: configure(8'($urandom), 1'b1);
            endcase
            stall_mode = rx_mode_e'(phase % 4);
            gaps_on    = (phase % 3) != 1;
            if (phase == 2) begin
                // The receiver holds off while requests keep coming.
                holds_requested++;
                burst_left = 60;
                repeat (40) begin
                    if ($urandom_range(0, 1) != 0) tick();
                    else rd(pick_index());
                end
            end
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    timer_program();
                end else if (roll < 75) begin
                    ipi_sequence();
                end else begin
                    repeat ($urandom_range(1, 5)) noise_item();
                end
                if (phase == 5 && !paused && items_sent > target - RANDOM_ITEMS / 16) begin
                    paused = 1'b1;
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (mirror.pending() != 0) begin
            mirror.report_mismatch("responses still outstanding at the end");
        end
        if (mirror.error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
